[sv/bmf_pkg.sv]
// shared types and constants for the box mean filter
package bmf_pkg;

    // reciprocal scaling for the window-area division
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 21;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_KERNEL_HALF  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam int CFG_DATA_W   = 11;
    localparam int ROW_W        = 10;
    localparam int HEIGHT_LIMIT = 1024;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic column;
        logic sum;
        logic mul;
        logic load;
    } bmf_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic has_result;
        logic out_free;
    } bmf_status_t;

    // ceil(2^20 / (k*k)) for k = 2*half+1, half 0..3
    function automatic logic [RECIP_W-1:0] recip_of_half(input logic [1:0] half);
        logic [RECIP_W-1:0] m;
        begin
            case (half)
                2'd0:    m = 21'd1048576;
                2'd1:    m = 21'd116509;
                2'd2:    m = 21'd41944;
                2'd3:    m = 21'd21400;
                default: m = 21'd1048576;
            endcase
            return m;
        end
    endfunction

endpackage

[sv/bmf_ctrl.sv]
// sequencing state machine for the box mean filter
module bmf_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bmf_pkg::bmf_status_t status,
    output bmf_pkg::bmf_cmd_t    cmd
);
    import bmf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_COL  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_COL;
                end
            end
            S_COL:
            begin
                cmd.column = 1'b1;
                state_next = status.has_result ? S_SUM : S_IDLE;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/bmf_datapath.sv]
// line store, column sums, window sum, divider and output register
module bmf_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 7
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [7:0]                       pixel,
    input  logic                             cfg_valid,
    input  logic [1:0]                       cfg_index,
    input  logic [bmf_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [7:0]                       mean_value,
    output logic                             last_of_frame,
    output logic                             out_valid,
    input  logic                             out_ready,
    input  bmf_pkg::bmf_cmd_t                cmd,
    output bmf_pkg::bmf_status_t             status
);
    import bmf_pkg::*;

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW   = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
    localparam int HR   = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
    localparam int CSW  = 8 + $clog2(MAX_KERNEL + 1);
    localparam int SW   = 8 + $clog2(MAX_KERNEL * MAX_KERNEL + 1);
    localparam int LIM  = (MAX_KERNEL - 1) / 2;
    localparam int PW   = SW + RECIP_W;

    // configuration
    logic [1:0]            kernel_half_reg;
    logic [CFG_DATA_W-1:0] image_width_reg;
    logic [CFG_DATA_W-1:0] image_height_reg;

    // counters
    logic [CW-1:0]    col_reg;
    logic [ROW_W-1:0] row_reg;

    // per-item payload
    logic [7:0]        pixel_reg;
    logic [8*HR-1:0]   mem_rd_reg;
    logic [CSW-1:0]    colsum_reg [MAX_KERNEL];
    logic              last_reg;
    logic [SW-1:0]     wsum_reg;
    logic [PW-1:0]     prod_reg;
    logic [7:0]        mean_reg;
    logic              last_out_reg;
    logic              out_valid_reg;

    logic [8*HR-1:0]   line_mem [MAX_WIDTH];

    logic [1:0]        h_eff;
    logic [4:0]        k_eff;
    logic [EW-1:0]     w_eff;
    logic [EW-1:0]     ht_eff;
    logic [CSW-1:0]    csum;
    logic [8*HR-1:0]   mem_wr;
    logic [SW-1:0]     wsum;
    logic [EW-1:0]     col_ext;
    logic [EW-1:0]     row_ext;
    logic [EW-1:0]     col_inc;
    logic [EW-1:0]     row_inc;
    logic [EW-1:0]     twoh;

    // effective settings
    always_comb
    begin
        if (int'(kernel_half_reg) > LIM)
        begin
            h_eff = 2'(LIM);
        end
        else
        begin
            h_eff = kernel_half_reg;
        end
        k_eff = {2'b00, h_eff, 1'b1};
        twoh  = EW'({h_eff, 1'b0});
        if (image_width_reg == '0)
        begin
            w_eff = EW'(1);
        end
        else if (EW'(image_width_reg) > EW'(MAX_WIDTH))
        begin
            w_eff = EW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = EW'(image_width_reg);
        end
        if (image_height_reg == '0)
        begin
            ht_eff = EW'(1);
        end
        else if (EW'(image_height_reg) > EW'(HEIGHT_LIMIT))
        begin
            ht_eff = EW'(HEIGHT_LIMIT);
        end
        else
        begin
            ht_eff = EW'(image_height_reg);
        end
        col_ext = EW'(col_reg);
        row_ext = EW'(row_reg);
        col_inc = col_ext + EW'(1);
        row_inc = row_ext + EW'(1);
    end

    // new column sum and shifted line store word
    always_comb
    begin
        csum = CSW'(pixel_reg);
        for (int r = 1; r < MAX_KERNEL; r++)
        begin
            if (r < int'(k_eff))
            begin
                csum = csum + CSW'(mem_rd_reg[8*(r-1) +: 8]);
            end
        end
        mem_wr = (mem_rd_reg << 8) | (8*HR)'(pixel_reg);
    end

    // window sum over the active column sums
    always_comb
    begin
        wsum = '0;
        for (int c = 0; c < MAX_KERNEL; c++)
        begin
            if (c < int'(k_eff))
            begin
                wsum = wsum + SW'(colsum_reg[c]);
            end
        end
    end

    // line store memory
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mem_rd_reg <= line_mem[col_reg];
        end
        if (cmd.column)
        begin
            line_mem[col_reg] <= mem_wr;
        end
    end

    // configuration and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_half_reg  <= 2'd3;
            image_width_reg  <= CFG_DATA_W'(512);
            image_height_reg <= CFG_DATA_W'(512);
            col_reg          <= '0;
            row_reg          <= '0;
        end
        else if (cfg_valid && (cfg_index == CFG_KERNEL_HALF ||
                               cfg_index == CFG_IMAGE_WIDTH ||
                               cfg_index == CFG_IMAGE_HEIGHT))
        begin
            case (cfg_index)
                CFG_KERNEL_HALF:  kernel_half_reg  <= cfg_data[1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:          kernel_half_reg  <= kernel_half_reg;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.column)
        begin
            if (col_inc >= w_eff)
            begin
                col_reg <= '0;
                if (row_inc >= ht_eff)
                begin
                    row_reg <= '0;
                end
                else
                begin
                    row_reg <= ROW_W'(row_inc);
                end
            end
            else
            begin
                col_reg <= CW'(col_inc);
            end
        end
    end

    // column sum window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_KERNEL; c++)
            begin
                colsum_reg[c] <= '0;
            end
        end
        else if (cmd.column)
        begin
            for (int c = 0; c < MAX_KERNEL; c++)
            begin
                if (c + 1 < int'(k_eff) && c + 1 < MAX_KERNEL)
                begin
                    colsum_reg[c] <= colsum_reg[(c + 1 < MAX_KERNEL) ? c + 1 : c];
                end
                else if (c + 1 == int'(k_eff))
                begin
                    colsum_reg[c] <= csum;
                end
            end
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pixel_reg <= pixel;
        end
        if (cmd.column)
        begin
            last_reg <= (row_inc == ht_eff) && (col_inc == w_eff);
        end
        if (cmd.sum)
        begin
            wsum_reg <= wsum;
        end
        if (cmd.mul)
        begin
            prod_reg <= PW'(wsum_reg) * PW'(recip_of_half(h_eff));
        end
        if (cmd.load)
        begin
            mean_reg     <= prod_reg[RECIP_SHIFT +: 8];
            last_out_reg <= last_reg;
        end
    end

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.has_result = (row_ext >= twoh) && (col_ext >= twoh);
    assign status.out_free   = !out_valid_reg || out_ready;
    assign mean_value        = mean_reg;
    assign last_of_frame     = last_out_reg;
    assign out_valid         = out_valid_reg;

endmodule

[sv/box_mean_filter_unit.sv]
// top level of the box mean filter
// Box mean filter over a raster stream of 8-bit grey pixels. Each pixel beat
// on the frame border takes a line store read, then a column update; a beat
// that gives a result adds to those the window sum, the reciprocal multiply
// and loading the output register, which waits until that register is free;
// the output register lets the next pixel in while a result waits. The pace
// is set by the single-port line store read and the one shared sum and
// multiply path. A frame of W x H gives (W-2h) x (H-2h) results, the last one
// flagged by last_of_frame. A write to any of the three configuration registers restarts the frame.
module box_mean_filter_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 7
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     pixel,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     mean_value,
    output logic                           last_of_frame,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [bmf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bmf_pkg::*;

    bmf_cmd_t    cmd;
    bmf_status_t status;

    assign cfg_ready = 1'b1;

    // sequencer
    bmf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    bmf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel         (pixel),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mean_value    (mean_value),
        .last_of_frame (last_of_frame),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cmd           (cmd),
        .status        (status)
    );

endmodule
